FILE: hdl/lrpe_pkg.sv
// lrpe_pkg: types and codes shared by the lr parse engine modules
// no dependencies
package lrpe_pkg;

    localparam int unsigned STATE_W   = 8;
    localparam int unsigned SYM_W     = 8;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned CNT_W     = 6;
    localparam int unsigned KIND_W    = 3;
    localparam logic [CNT_W-1:0] MAX_RED = 6'd62;
    localparam logic [0:0] REG_END_TOKEN = 1'b0;

    typedef enum logic [1:0] {
        OP_JUMP    = 2'd0,
        OP_RED     = 2'd1,
        OP_RESTART = 2'd2,
        OP_TOKEN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EK_END    = 2'd0,
        EK_TOKEN  = 2'd1,
        EK_TOKVAL = 2'd2,
        EK_GOTO   = 2'd3
    } ekind_t;

    typedef enum logic [KIND_W-1:0] {
        RK_REDUCED  = 3'd0,
        RK_SHIFTED  = 3'd1,
        RK_ACCEPTED = 3'd2,
        RK_FAILED   = 3'd3,
        RK_DONE     = 3'd4
    } rkind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_JRD,
        B_JCHK,
        B_RED,
        B_POP,
        B_FAIL
    } bstate_t;

    typedef struct packed {
        op_t                op;
        logic [STATE_W-1:0] state_index;
        logic [3:0]         slot;
        ekind_t             entry_kind;
        logic [SYM_W-1:0]   symbol;
        logic [VAL_W-1:0]   token_value;
        logic [STATE_W-1:0] target_state;
        logic               has_reduction;
        logic [SYM_W-1:0]   reduce_symbol;
        logic [CNT_W-1:0]   reduce_count;
    } cmd_t;

    typedef struct packed {
        ekind_t             kind;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] tgt;
        logic [VAL_W-1:0]   val;
    } jump_entry_t;

    typedef struct packed {
        logic             has;
        logic [SYM_W-1:0] sym;
        logic [CNT_W-1:0] cnt;
    } red_entry_t;

endpackage

FILE: hdl/lrpe_front.sv
// lrpe_front: input handshake and two-entry command queue
// depends on lrpe_pkg
module lrpe_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lrpe_pkg::cmd_t       in_cmd,
    output logic                 cmd_valid,
    output lrpe_pkg::cmd_t       cmd,
    input  logic                 cmd_pop
);
    import lrpe_pkg::*;

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;

    assign s_ready   = (fill_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_comb begin
        wp_next   = push ? ~wp_reg : wp_reg;
        rp_next   = cmd_pop ? ~rp_reg : rp_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

FILE: hdl/lrpe_back.sv
// lrpe_back: table memories, state stack and the parse sequencer with output register
// depends on lrpe_pkg
module lrpe_back #(
    parameter int unsigned NUM_STATES      = 256,
    parameter int unsigned JUMPS_PER_STATE = 16,
    parameter int unsigned STACK_DEPTH     = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    input  lrpe_pkg::cmd_t                  cmd,
    output logic                            cmd_pop,
    input  logic [lrpe_pkg::SYM_W-1:0]      end_token_type,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lrpe_pkg::KIND_W-1:0]     m_kind,
    output logic [lrpe_pkg::SYM_W-1:0]      m_reduced_symbol,
    output logic [lrpe_pkg::CNT_W-1:0]      m_reduced_count,
    output logic [lrpe_pkg::STATE_W-1:0]    m_new_state,
    output logic                            m_last
);
    import lrpe_pkg::*;

    localparam int unsigned JDEPTH = NUM_STATES * JUMPS_PER_STATE;
    localparam int unsigned JW     = $clog2(JDEPTH);
    localparam int unsigned RW     = $clog2(NUM_STATES);
    localparam int unsigned IW     = $clog2(JUMPS_PER_STATE);
    localparam int unsigned CW     = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW     = $clog2(STACK_DEPTH);

    jump_entry_t        jmem [JDEPTH];
    red_entry_t         rmem [NUM_STATES];
    logic [STATE_W-1:0] smem [STACK_DEPTH];

    bstate_t            state_reg, state_next;
    logic [STATE_W-1:0] top_reg, top_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               goto_reg, goto_next;
    logic [CNT_W-1:0]   redn_reg, redn_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [SYM_W-1:0]   csym_reg, csym_next;
    logic [CNT_W-1:0]   ccnt_reg, ccnt_next;
    jump_entry_t        jrd_reg;
    red_entry_t         rrd_reg;
    logic [STATE_W-1:0] srd_reg;

    logic               mv_reg;
    rkind_t             mk_reg;
    logic [SYM_W-1:0]   ms_reg;
    logic [CNT_W-1:0]   mc_reg;
    logic [STATE_W-1:0] mn_reg;
    logic               ml_reg;

    logic               out_free;
    logic               emit;
    rkind_t             e_kind;
    logic [SYM_W-1:0]   e_sym;
    logic [CNT_W-1:0]   e_cnt;
    logic [STATE_W-1:0] e_state;
    logic               e_last;

    logic               jwe, rwe, swe, rd_en, srd_en;
    logic [JW-1:0]      jwaddr, jraddr;
    logic [RW-1:0]      rwaddr, rraddr;
    logic [CW-1:0]      cnt_m1, pop_cnt, pop_m1;
    logic [AW-1:0]      swaddr, sraddr;
    logic               jw_ok, rw_ok, last_slot, tgt_ok, tok_hit;

    assign out_free = !mv_reg || m_ready;
    assign jw_ok    = (32'(cmd.state_index) < 32'(NUM_STATES))
                   && (32'(cmd.slot) < 32'(JUMPS_PER_STATE));
    assign rw_ok    = 32'(cmd.state_index) < 32'(NUM_STATES);
    assign jwaddr   = JW'(32'(cmd.state_index) * 32'(JUMPS_PER_STATE) + 32'(cmd.slot));
    assign jraddr   = JW'(32'(top_reg) * 32'(JUMPS_PER_STATE) + 32'(idx_reg));
    assign rwaddr   = RW'(cmd.state_index);
    assign rraddr   = RW'(top_reg);
    assign cnt_m1   = count_reg - CW'(1);
    assign swaddr   = cnt_m1[AW-1:0];
    assign pop_cnt  = count_reg - CW'(rrd_reg.cnt);
    assign pop_m1   = pop_cnt - CW'(1);
    assign sraddr   = pop_m1[AW-1:0];
    assign last_slot = (idx_reg == IW'(JUMPS_PER_STATE - 1));
    assign tgt_ok   = (32'(jrd_reg.tgt) < 32'(NUM_STATES))
                   && (32'(count_reg) < 32'(STACK_DEPTH));
    assign tok_hit  = (jrd_reg.sym == sym_reg)
                   && ((jrd_reg.kind == EK_TOKEN)
                       || (jrd_reg.kind == EK_TOKVAL && jrd_reg.val == val_reg));

    always_comb begin
        state_next = state_reg;
        top_next   = top_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        goto_next  = goto_reg;
        redn_next  = redn_reg;
        sym_next   = sym_reg;
        val_next   = val_reg;
        csym_next  = csym_reg;
        ccnt_next  = ccnt_reg;
        cmd_pop    = 1'b0;
        jwe        = 1'b0;
        rwe        = 1'b0;
        swe        = 1'b0;
        rd_en      = 1'b0;
        srd_en     = 1'b0;
        emit       = 1'b0;
        e_kind     = RK_DONE;
        e_sym      = '0;
        e_cnt      = '0;
        e_state    = top_reg;
        e_last     = 1'b1;
        unique case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.op)
                        OP_JUMP: begin
                            if (out_free) begin
                                cmd_pop = 1'b1;
                                jwe     = jw_ok;
                                emit    = 1'b1;
                            end
                        end
                        OP_RED: begin
                            if (out_free) begin
                                cmd_pop = 1'b1;
                                rwe     = rw_ok;
                                emit    = 1'b1;
                            end
                        end
                        OP_RESTART: begin
                            if (out_free) begin
                                cmd_pop    = 1'b1;
                                count_next = CW'(1);
                                top_next   = '0;
                                emit       = 1'b1;
                                e_state    = '0;
                            end
                        end
                        default: begin
                            cmd_pop    = 1'b1;
                            sym_next   = cmd.symbol;
                            val_next   = cmd.token_value;
                            redn_next  = '0;
                            idx_next   = '0;
                            goto_next  = 1'b0;
                            state_next = (count_reg == '0) ? B_FAIL : B_JRD;
                        end
                    endcase
                end
            end
            B_JRD: begin
                rd_en      = 1'b1;
                state_next = B_JCHK;
            end
            B_JCHK: begin
                if (!goto_reg) begin
                    if (jrd_reg.kind == EK_END) begin
                        state_next = B_RED;
                    end else if (tok_hit) begin
                        if (!tgt_ok) begin
                            state_next = B_FAIL;
                        end else if (out_free) begin
                            swe        = 1'b1;
                            top_next   = jrd_reg.tgt;
                            count_next = count_reg + CW'(1);
                            emit       = 1'b1;
                            e_kind     = RK_SHIFTED;
                            e_state    = jrd_reg.tgt;
                            state_next = B_IDLE;
                        end
                    end else if (last_slot) begin
                        state_next = B_RED;
                    end else begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = B_JRD;
                    end
                end else begin
                    if (jrd_reg.kind == EK_END) begin
                        state_next = B_FAIL;
                    end else if (jrd_reg.kind == EK_GOTO && jrd_reg.sym == csym_reg) begin
                        if (!tgt_ok) begin
                            state_next = B_FAIL;
                        end else if (out_free) begin
                            swe        = 1'b1;
                            top_next   = jrd_reg.tgt;
                            count_next = count_reg + CW'(1);
                            emit       = 1'b1;
                            e_kind     = RK_REDUCED;
                            e_sym      = csym_reg;
                            e_cnt      = ccnt_reg;
                            e_state    = jrd_reg.tgt;
                            e_last     = 1'b0;
                            redn_next  = redn_reg + CNT_W'(1);
                            idx_next   = '0;
                            goto_next  = 1'b0;
                            state_next = B_JRD;
                        end
                    end else if (last_slot) begin
                        state_next = B_FAIL;
                    end else begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = B_JRD;
                    end
                end
            end
            B_RED: begin
                if (!rrd_reg.has) begin
                    state_next = B_FAIL;
                end else if (sym_reg == end_token_type && rrd_reg.sym == '0) begin
                    if (out_free) begin
                        count_next = '0;
                        top_next   = '0;
                        emit       = 1'b1;
                        e_kind     = RK_ACCEPTED;
                        e_state    = '0;
                        state_next = B_IDLE;
                    end
                end else if (redn_reg >= MAX_RED
                             || 32'(rrd_reg.cnt) >= 32'(count_reg)) begin
                    state_next = B_FAIL;
                end else begin
                    csym_next  = rrd_reg.sym;
                    ccnt_next  = rrd_reg.cnt;
                    count_next = pop_cnt;
                    idx_next   = '0;
                    goto_next  = 1'b1;
                    if (rrd_reg.cnt == '0) begin
                        state_next = B_JRD;
                    end else begin
                        srd_en     = 1'b1;
                        state_next = B_POP;
                    end
                end
            end
            B_POP: begin
                top_next   = srd_reg;
                state_next = B_JRD;
            end
            B_FAIL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = RK_FAILED;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            top_reg   <= '0;
            count_reg <= CW'(1);
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            count_reg <= count_next;
            if (emit) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        goto_reg <= goto_next;
        redn_reg <= redn_next;
        sym_reg  <= sym_next;
        val_reg  <= val_next;
        csym_reg <= csym_next;
        ccnt_reg <= ccnt_next;
        if (emit) begin
            mk_reg <= e_kind;
            ms_reg <= e_sym;
            mc_reg <= e_cnt;
            mn_reg <= e_state;
            ml_reg <= e_last;
        end
    end

    // table and stack memories, registered reads
    always_ff @(posedge aclk) begin
        if (jwe) begin
            jmem[jwaddr] <= '{kind: cmd.entry_kind, sym: cmd.symbol,
                              tgt: cmd.target_state, val: cmd.token_value};
        end
        if (rd_en) begin
            jrd_reg <= jmem[jraddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rwe) begin
            rmem[rwaddr] <= '{has: cmd.has_reduction, sym: cmd.reduce_symbol,
                              cnt: cmd.reduce_count};
        end
        if (rd_en) begin
            rrd_reg <= rmem[rraddr];
        end
    end

    // entries below the top of stack; the top itself lives in top_reg
    always_ff @(posedge aclk) begin
        if (swe) begin
            smem[swaddr] <= top_reg;
        end
        if (srd_en) begin
            srd_reg <= smem[sraddr];
        end
    end

    assign m_valid          = mv_reg;
    assign m_kind           = mk_reg;
    assign m_reduced_symbol = ms_reg;
    assign m_reduced_count  = mc_reg;
    assign m_new_state      = mn_reg;
    assign m_last           = ml_reg;

endmodule

FILE: hdl/lr_parse_engine_unit.sv
// lr parse engine: a load or restart item passes the front queue and then the output register;
// a token enters the sequencer, each jump entry is read and then checked (token and goto scans
// share one table read port), each reduction is checked, a popping reduction passes a pop state
// and a failure is reported; a stalled result holds the sequencer until taken; loads and restarts
// sustain one item per cycle while output is free, tokens run one at a time (up to 62 reductions)
// reset: synchronous active low, stack holds state 0, end token type 0, tables undefined
// lr_parse_engine_unit: top level with config register, front queue and back sequencer
// depends on lrpe_pkg, lrpe_front, lrpe_back
module lr_parse_engine_unit #(
    parameter int unsigned NUM_STATES      = 256,
    parameter int unsigned JUMPS_PER_STATE = 16,
    parameter int unsigned STACK_DEPTH     = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic [7:0]                    s_state_index,
    input  logic [3:0]                    s_slot,
    input  logic [1:0]                    s_entry_kind,
    input  logic [7:0]                    s_symbol,
    input  logic signed [31:0]            s_token_value,
    input  logic [7:0]                    s_target_state,
    input  logic                          s_has_reduction,
    input  logic [7:0]                    s_reduce_symbol,
    input  logic [5:0]                    s_reduce_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_kind,
    output logic [7:0]                    m_reduced_symbol,
    output logic [5:0]                    m_reduced_count,
    output logic [7:0]                    m_new_state,
    output logic                          m_last
);
    import lrpe_pkg::*;

    logic [SYM_W-1:0] end_tok_reg;
    logic             cfg_wr;
    cmd_t             in_cmd;
    cmd_t             cmd;
    logic             cmd_valid;
    logic             cmd_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_END_TOKEN);
    assign prdata = (paddr[2] == REG_END_TOKEN) ? 32'(end_tok_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_tok_reg <= '0;
        end else if (cfg_wr) begin
            end_tok_reg <= pwdata[SYM_W-1:0];
        end
    end

    always_comb begin
        in_cmd.op            = op_t'(s_op);
        in_cmd.state_index   = s_state_index;
        in_cmd.slot          = s_slot;
        in_cmd.entry_kind    = ekind_t'(s_entry_kind);
        in_cmd.symbol        = s_symbol;
        in_cmd.token_value   = s_token_value;
        in_cmd.target_state  = s_target_state;
        in_cmd.has_reduction = s_has_reduction;
        in_cmd.reduce_symbol = s_reduce_symbol;
        in_cmd.reduce_count  = s_reduce_count;
    end

    lrpe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    lrpe_back #(
        .NUM_STATES      (NUM_STATES),
        .JUMPS_PER_STATE (JUMPS_PER_STATE),
        .STACK_DEPTH     (STACK_DEPTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd),
        .cmd_pop          (cmd_pop),
        .end_token_type   (end_tok_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_reduced_symbol (m_reduced_symbol),
        .m_reduced_count  (m_reduced_count),
        .m_new_state      (m_new_state),
        .m_last           (m_last)
    );

endmodule
